// ===== hw/rtl/fbud_pkg.sv =====
// ----------------------------------------------------------------------------
// fbud_pkg
// shared types, character codes and helpers of the form body decoder
// ----------------------------------------------------------------------------
package fbud_pkg;

   // result kinds as seen on the result port
   typedef enum logic [2:0] {
      KIND_NAME      = 3'd0,
      KIND_VALUE     = 3'd1,
      KIND_PAIR_END  = 3'd2,
      KIND_NO_EQUALS = 3'd3,
      KIND_BODY_END  = 3'd4
   } kind_type;

   // percent escape tracking
   typedef enum logic [1:0] {
      ESC_IDLE    = 2'd0,
      ESC_PERCENT = 2'd1,
      ESC_DIGIT   = 2'd2
   } esc_type;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } result_type;

   // one queue entry: the results of one input transaction
   typedef struct packed {
      result_type r0;
      result_type r1;
      logic       two;
   } entry_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         res = {1'b1, 4'(ch - 8'h57)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         res = {1'b1, 4'(ch - 8'h37)};
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/form_body_url_decoder_core.sv =====
// ----------------------------------------------------------------------------
// form_body_url_decoder_core
// Streaming decoder for a form-urlencoded body. One raw body byte is taken
// per cycle while req_ready is high; it is percent-decoded (hex digits of
// either case, a bad digit gives a literal percent sign) and split into
// name bytes, value bytes ('+' becomes a space in values), pair ends on '&'
// in a value, and one closing marker with rsp_out_last set: pair end,
// missing-equals error or body end. A raw or decoded zero ends the body
// early; later bytes are dropped up to the one flagged last. Each
// transaction yields zero, one or two results. The front decoder is
// combinational, so req_ready stays high at one transaction per cycle as
// long as the four-entry queue has room; the result port drains one result
// per cycle while rsp_ready is high, so a run of transactions that each
// give two results fills the queue and then stalls req_ready, as the single
// output register holds one result at a time. A first result passes through
// the queue and then the output register; a second result follows it.
// ----------------------------------------------------------------------------
module form_body_url_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_out_kind,
   output logic       rsp_out_last
);

   // front to queue
   logic                 accept;
   logic                 q_push;
   fbud_pkg::entry_type  q_push_entry;
   logic                 q_full;

   // queue to back
   logic                 q_pop;
   logic                 q_head_valid;
   fbud_pkg::entry_type  q_head_entry;

   fbud_pkg::result_type rsp_result;

   // input side only waits on a full queue
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   fbud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // holds the result groups of up to four transactions
   fbud_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   // one result per cycle out of the registered output stage while rsp_ready is high
   fbud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

   assign rsp_out_byte = rsp_result.data;
   assign rsp_out_kind = rsp_result.kind;
   assign rsp_out_last = rsp_result.last;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // the front never writes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   // the final result of a body is always one of the closing markers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |->
         (rsp_out_kind == fbud_pkg::KIND_PAIR_END ||
          rsp_out_kind == fbud_pkg::KIND_NO_EQUALS ||
          rsp_out_kind == fbud_pkg::KIND_BODY_END))
      else $error("last result is not a closing marker");

   // marker results carry no character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind != fbud_pkg::KIND_NAME &&
       rsp_out_kind != fbud_pkg::KIND_VALUE) |-> (rsp_out_byte == fbud_pkg::CHAR_NUL))
      else $error("marker result with nonzero byte");

   // plus is always turned into a space in values
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == fbud_pkg::KIND_VALUE) |->
         (rsp_out_byte != fbud_pkg::CHAR_PLUS))
      else $error("unmapped plus in value");

endmodule

// ===== hw/rtl/fbud_front.sv =====
// ----------------------------------------------------------------------------
// fbud_front
// percent decoding and name/value split, one raw byte per cycle while accept is high
// ----------------------------------------------------------------------------
module fbud_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 push,
   output fbud_pkg::entry_type  push_entry
);

   fbud_pkg::esc_type esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic       value_ff, value_in;
   logic       started_ff, started_in;
   logic       stopped_ff, stopped_in;

   logic                 have;
   logic                 finish;
   logic [7:0]           ch;
   logic [4:0]           h1;
   logic [4:0]           h2;
   logic                 first_ok;
   fbud_pkg::result_type first;
   fbud_pkg::result_type marker;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= fbud_pkg::ESC_IDLE;
      end else if (accept) begin
         esc_ff <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= 1'b0;
         started_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         value_ff   <= value_in;
         started_ff <= started_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   always_comb begin
      esc_in     = esc_ff;
      held_in    = held_ff;
      value_in   = value_ff;
      started_in = started_ff;
      stopped_in = stopped_ff;
      have       = 1'b0;
      finish     = in_last;
      ch         = fbud_pkg::CHAR_NUL;
      h1         = fbud_pkg::hex_decode(held_ff);
      h2         = fbud_pkg::hex_decode(in_byte);
      first_ok   = 1'b0;
      first      = '{data: fbud_pkg::CHAR_NUL, kind: fbud_pkg::KIND_NAME, last: 1'b0};
      marker     = '{data: fbud_pkg::CHAR_NUL, kind: fbud_pkg::KIND_BODY_END, last: 1'b1};

      if (stopped_ff) begin
         // swallow the rest of an early-ended body
         finish = 1'b0;
         if (in_last) begin
            esc_in     = fbud_pkg::ESC_IDLE;
            value_in   = 1'b0;
            started_in = 1'b0;
            stopped_in = 1'b0;
         end
      end else begin
         unique case (esc_ff)
            fbud_pkg::ESC_IDLE: begin
               if (in_byte == fbud_pkg::CHAR_NUL) begin
                  finish = 1'b1;
               end else if (in_byte == fbud_pkg::CHAR_PERCENT) begin
                  if (in_last) begin
                     have = 1'b1;
                     ch   = fbud_pkg::CHAR_PERCENT;
                  end else begin
                     esc_in = fbud_pkg::ESC_PERCENT;
                  end
               end else begin
                  have = 1'b1;
                  ch   = in_byte;
               end
            end
            fbud_pkg::ESC_PERCENT: begin
               if (in_byte == fbud_pkg::CHAR_NUL || in_last) begin
                  have   = 1'b1;
                  ch     = fbud_pkg::CHAR_PERCENT;
                  finish = 1'b1;
                  esc_in = fbud_pkg::ESC_IDLE;
               end else begin
                  held_in = in_byte;
                  esc_in  = fbud_pkg::ESC_DIGIT;
               end
            end
            fbud_pkg::ESC_DIGIT: begin
               esc_in = fbud_pkg::ESC_IDLE;
               if (in_byte == fbud_pkg::CHAR_NUL) begin
                  have   = 1'b1;
                  ch     = fbud_pkg::CHAR_PERCENT;
                  finish = 1'b1;
               end else if (h1[4] && h2[4]) begin
                  ch = {h1[3:0], h2[3:0]};
                  if (ch == fbud_pkg::CHAR_NUL) begin
                     finish = 1'b1;
                  end else begin
                     have = 1'b1;
                  end
               end else begin
                  have = 1'b1;
                  ch   = fbud_pkg::CHAR_PERCENT;
               end
            end
            default: begin
               esc_in = fbud_pkg::ESC_IDLE;
            end
         endcase

         if (have) begin
            if (!value_ff) begin
               if (ch == fbud_pkg::CHAR_EQUALS) begin
                  value_in   = 1'b1;
                  started_in = 1'b0;
               end else begin
                  first_ok   = 1'b1;
                  first.data = ch;
                  first.kind = fbud_pkg::KIND_NAME;
                  started_in = 1'b1;
               end
            end else if (ch == fbud_pkg::CHAR_AMP) begin
               first_ok   = 1'b1;
               first.kind = fbud_pkg::KIND_PAIR_END;
               value_in   = 1'b0;
               started_in = 1'b0;
            end else begin
               first_ok   = 1'b1;
               first.data = (ch == fbud_pkg::CHAR_PLUS) ? fbud_pkg::CHAR_SPACE : ch;
               first.kind = fbud_pkg::KIND_VALUE;
            end
         end

         if (finish) begin
            // end marker follows the parser phase after this byte
            if (value_in) begin
               marker.kind = fbud_pkg::KIND_PAIR_END;
            end else if (started_in) begin
               marker.kind = fbud_pkg::KIND_NO_EQUALS;
            end else begin
               marker.kind = fbud_pkg::KIND_BODY_END;
            end
            esc_in     = fbud_pkg::ESC_IDLE;
            value_in   = 1'b0;
            started_in = 1'b0;
            stopped_in = !in_last;
         end
      end

      push = accept && (first_ok || finish);
      if (first_ok) begin
         push_entry = '{r0: first, r1: marker, two: finish};
      end else begin
         push_entry = '{r0: marker, r1: marker, two: 1'b0};
      end
   end

endmodule

// ===== hw/rtl/fbud_queue.sv =====
// ----------------------------------------------------------------------------
// fbud_queue
// short fifo of result groups between front and back
// ----------------------------------------------------------------------------
module fbud_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fbud_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output fbud_pkg::entry_type  head_entry
);

   fbud_pkg::entry_type            store_ff [fbud_pkg::QUEUE_DEPTH];
   logic [fbud_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fbud_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fbud_pkg::QUEUE_AW:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full       = (count_ff == (fbud_pkg::QUEUE_AW+1)'(fbud_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/fbud_back.sv =====
// ----------------------------------------------------------------------------
// fbud_back
// splits result groups into single results behind an output register
// ----------------------------------------------------------------------------
module fbud_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  fbud_pkg::entry_type   head_entry,
   output logic                  pop,
   input  logic                  out_ready,
   output logic                  out_valid,
   output fbud_pkg::result_type  out_result
);

   logic                 valid_ff, valid_in;
   logic                 half_ff, half_in;
   fbud_pkg::result_type res_ff;
   fbud_pkg::result_type sel;
   logic                 load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= sel;
      end
   end

   always_comb begin
      sel      = half_ff ? head_entry.r1 : head_entry.r0;
      load     = head_valid && (!valid_ff || out_ready);
      valid_in = valid_ff;
      half_in  = half_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (half_ff || !head_entry.two) begin
            pop     = 1'b1;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;

endmodule
